### rtl/core/kxc_pkg.sv
// ----------------------------------------------------------------------------
// kxc_pkg - shared definitions for the keyed square-index XOR cipher
// Constants, operation and register codes, sequencer states and the key
// byte reshaping function.
// ----------------------------------------------------------------------------
package kxc_pkg;

	localparam int unsigned KEY_DEPTH = 256;
	localparam int unsigned KEY_AW    = $clog2(KEY_DEPTH);
	localparam int unsigned LEN_W     = KEY_AW + 1;
	localparam int unsigned PAGE_W    = 15;
	localparam int unsigned SUM_W     = 32;

	localparam logic [PAGE_W-1:0] PAGE_LEN      = 15'h7fff;
	localparam logic [SUM_W-1:0]  OFFSET_STATIC = 32'd80923;
	localparam logic [SUM_W-1:0]  OFFSET_MAP    = 32'd71214;
	localparam logic [2:0]        SHIFT_BIAS    = 3'd4;

	// operation codes of a request
	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_DATA = 1'b1;

	// configuration register indexes
	localparam logic REG_CIPHER_MODE = 1'b0;
	localparam logic REG_KEY_LENGTH  = 1'b1;

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_MUL   = 5'b00010,
		ST_DIV   = 5'b00100,
		ST_READ  = 5'b01000,
		ST_WRITE = 5'b10000
	} state_t;

	// rotate-like reshaping: ((v << s) | (v >> s)) truncated to a byte
	function automatic logic [7:0] reshape(input logic [7:0] v, input logic [KEY_AW-1:0] a);
		logic [2:0]  s;
		logic [15:0] wide;
		logic [7:0]  hi;
		logic [7:0]  lo;
		s    = a[2:0] + SHIFT_BIAS;
		wide = {8'd0, v} << s;
		hi   = wide[7:0];
		lo   = v >> s;
		return hi | lo;
	endfunction

endpackage

### rtl/core/keyed_square_index_xor_cipher.sv
// ----------------------------------------------------------------------------
// keyed_square_index_xor_cipher - byte stream XOR decryptor
// Key bytes are loaded into an on-chip key memory, then each data byte is
// XORed with the key byte at (p*p + K) mod key_length (reshaped in map mode), p being the page
// index that follows the stream position.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one request per transfer.
//   operation selects a key load (key_address, key_byte) or a data byte
//   decrypt (data_byte). A key load is written to the key memory at the
//   accepting edge and produces no result; the block is ready again at once.
//   A data request produces exactly one plain_byte on the output channel
//   (out_valid/out_ready). A data request occupies the block while it squares
//   the page index, runs the remainder unit over the 32-bit dividend (eight
//   quotient bits per cycle), reads the synchronous key memory and loads the
//   output register. The result becomes valid in the same cycle that the block
//   is ready again, and the next request is accepted even while the result
//   still waits.
//   If the receiver stalls, the result is held in the output register and
//   the sequencer waits in its final state until the register frees up.
//   Reset restarts the stream position (page index 0, first page), sets the
//   static cipher with key length 1; key memory content is undefined until
//   loaded. Configuration writes take effect immediately; the user must make
//   them only while the block is idle, as the block does not enforce it.
// ----------------------------------------------------------------------------
module keyed_square_index_xor_cipher (
	input  logic       clk,
	input  logic       arst_n,
	// configuration write port
	input  logic       cfg_we,
	input  logic       cfg_index,
	input  logic [8:0] cfg_wdata,
	// request channel
	input  logic       in_valid,
	output logic       in_ready,
	input  logic       operation,
	input  logic [7:0] key_address,
	input  logic [7:0] key_byte,
	input  logic [7:0] data_byte,
	// result channel
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] plain_byte
);

	localparam int unsigned AW  = kxc_pkg::KEY_AW;
	localparam int unsigned LW  = kxc_pkg::LEN_W;
	localparam int unsigned PW  = kxc_pkg::PAGE_W;
	localparam int unsigned SW  = kxc_pkg::SUM_W;
	localparam int unsigned BPC = 8;                // dividend bits per cycle
	localparam int unsigned DIV_CYC = SW / BPC;
	localparam int unsigned CW  = $clog2(DIV_CYC);

	// configuration registers
	logic          cipher_mode_q;
	logic [LW-1:0] key_length_q;

	// stream position
	logic [PW-1:0] page_q;
	logic          first_page_q;

	// sequencer and working registers
	kxc_pkg::state_t state_q;
	logic [PW-1:0]   page_s1;
	logic [7:0]      data_s1;
	logic [SW-1:0]   dividend_q;
	logic [AW-1:0]   rem_q;
	logic [CW-1:0]   div_cnt_q;

	// key memory
	logic [7:0] key_mem [kxc_pkg::KEY_DEPTH];
	logic [7:0] key_rdata_q;

	// result register
	logic       out_valid_q;
	logic [7:0] plain_q;

	logic          accept;
	logic          load_we;
	logic          out_free;
	logic [LW-1:0] eff_len;
	logic [2*PW-1:0] square;
	logic [SW-1:0]   sum;
	logic [AW-1:0]   rem_next;
	logic [7:0]      key_sel;

	assign in_ready  = (state_q == kxc_pkg::ST_IDLE);
	assign accept    = in_valid && in_ready;
	assign load_we   = accept && (operation == kxc_pkg::OP_LOAD);
	assign out_free  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;
	assign plain_byte = plain_q;

	// clamp the key length into 1..KEY_DEPTH
	always_comb begin
		priority if (key_length_q == '0) begin
			eff_len = LW'(1);
		end else if (key_length_q > LW'(kxc_pkg::KEY_DEPTH)) begin
			eff_len = LW'(kxc_pkg::KEY_DEPTH);
		end else begin
			eff_len = key_length_q;
		end
	end

	// square the page index and add the mode offset
	always_comb begin
		square = {{PW{1'b0}}, page_s1} * {{PW{1'b0}}, page_s1};
		sum    = SW'(square) + (cipher_mode_q ? kxc_pkg::OFFSET_MAP : kxc_pkg::OFFSET_STATIC);
	end

	// remainder unit: restoring steps over the next dividend byte
	always_comb begin
		logic [AW+1:0] t;
		logic [AW-1:0] r;
		r = rem_q;
		for (int i = 0; i < BPC; i++) begin
			t = {1'b0, r, dividend_q[SW-1-i]};
			if (t >= {1'b0, eff_len}) begin
				t = t - {1'b0, eff_len};
			end
			r = t[AW-1:0];
		end
		rem_next = r;
	end

	// reshape the key byte in map mode
	assign key_sel = cipher_mode_q ? kxc_pkg::reshape(key_rdata_q, rem_q) : key_rdata_q;

	// key memory: one write port for loads, one registered read port
	always_ff @(posedge clk) begin
		if (load_we) begin
			key_mem[key_address] <= key_byte;
		end
		key_rdata_q <= key_mem[rem_q];
	end

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cipher_mode_q <= 1'b0;
			key_length_q  <= LW'(1);
		end else if (cfg_we) begin
			unique case (cfg_index)
				kxc_pkg::REG_CIPHER_MODE: cipher_mode_q <= cfg_wdata[0];
				kxc_pkg::REG_KEY_LENGTH:  key_length_q  <= cfg_wdata[LW-1:0];
				default: ;
			endcase
		end
	end

	// sequencer, stream position and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= kxc_pkg::ST_IDLE;
			page_q       <= '0;
			first_page_q <= 1'b1;
			div_cnt_q    <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			// raise the result when written, drop it once taken
			if ((state_q == kxc_pkg::ST_WRITE) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				kxc_pkg::ST_IDLE: begin
					if (accept && (operation == kxc_pkg::OP_DATA)) begin
						state_q <= kxc_pkg::ST_MUL;
						// advance the page index for the next data byte
						if (first_page_q) begin
							if (page_q >= kxc_pkg::PAGE_LEN) begin
								page_q       <= PW'(1);
								first_page_q <= 1'b0;
							end else begin
								page_q <= page_q + PW'(1);
							end
						end else if (page_q >= kxc_pkg::PAGE_LEN - PW'(1)) begin
							page_q <= '0;
						end else begin
							page_q <= page_q + PW'(1);
						end
					end
				end
				kxc_pkg::ST_MUL: begin
					div_cnt_q <= '0;
					state_q   <= kxc_pkg::ST_DIV;
				end
				kxc_pkg::ST_DIV: begin
					div_cnt_q <= div_cnt_q + CW'(1);
					if (div_cnt_q == CW'(DIV_CYC - 1)) begin
						state_q <= kxc_pkg::ST_READ;
					end
				end
				kxc_pkg::ST_READ: begin
					state_q <= kxc_pkg::ST_WRITE;
				end
				kxc_pkg::ST_WRITE: begin
					// hold until the result register is free
					if (out_free) begin
						state_q <= kxc_pkg::ST_IDLE;
					end
				end
				default: state_q <= kxc_pkg::ST_IDLE;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			page_s1 <= page_q;
			data_s1 <= data_byte;
		end
		if (state_q == kxc_pkg::ST_MUL) begin
			dividend_q <= sum;
			rem_q      <= '0;
		end else if (state_q == kxc_pkg::ST_DIV) begin
			dividend_q <= dividend_q << BPC;
			rem_q      <= rem_next;
		end
		if ((state_q == kxc_pkg::ST_WRITE) && out_free) begin
			plain_q <= data_s1 ^ key_sel;
		end
	end

endmodule

### tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top - self-checking bench for the keyed square-index XOR cipher
// Loads the whole key memory, then runs requests through the block. Key loads
// and data bytes are mixed under several settings of the mode and key length
// registers. Each accepted data request is mirrored in a local cipher model,
// which queues the plain byte it predicts. Every result the block hands out is
// compared against the oldest queued byte. Idling on both channels is varied
// by phase. A long hold-off fills the block.
// ----------------------------------------------------------------------------
module tb_top;

	localparam int unsigned WATCHDOG_LIMIT = 3000;
	localparam int unsigned SETTLE_CYCLES  = 12;
	localparam int unsigned HOLD_CYCLES    = 400;
	localparam int unsigned RANDOM_BLOCK   = 70;

	logic       clk = 1'b0;
	logic       arst_n;
	logic       cfg_we;
	logic       cfg_index;
	logic [8:0] cfg_wdata;
	logic       in_valid;
	logic       in_ready;
	logic       operation;
	logic [7:0] key_address;
	logic [7:0] key_byte;
	logic [7:0] data_byte;
	logic       out_valid;
	logic       out_ready;
	logic [7:0] plain_byte;

	// local mirror of the cipher: key memory, stream position and registers
	logic [7:0]                 key_mirror [kxc_pkg::KEY_DEPTH];
	logic [kxc_pkg::PAGE_W-1:0] page_pos    = '0;
	logic                       first_page  = 1'b1;
	logic                       mode_shadow = 1'b0;
	logic [8:0]                 klen_shadow = 9'd1;

	// plain bytes predicted for accepted data requests, oldest first
	logic [7:0] pending_plain [$];
	logic [7:0] plain_want;

	int unsigned tx_idle_pct  = 0;
	int unsigned rx_stall_pct = 0;
	int unsigned rx_hold_left = 0;
	int unsigned quiet_cycles = 0;
	int unsigned mismatches   = 0;

	keyed_square_index_xor_cipher uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_wdata   (cfg_wdata),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.operation   (operation),
		.key_address (key_address),
		.key_byte    (key_byte),
		.data_byte   (data_byte),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.plain_byte  (plain_byte)
	);

	always #2 clk = ~clk;

	// ------------------------------------------------------------------------
	// Cipher model
	// ------------------------------------------------------------------------

	// Key byte for the current stream position: index (p*p + K) mod length,
	// length clamped to 1..KEY_DEPTH, and in map mode the byte reshaped as it
	// is read, so the mode in force at that moment applies.
	function automatic logic [7:0] selected_key();
		longint unsigned square;
		int unsigned     span;
		int unsigned     slot;
		int unsigned     s;
		logic [15:0]     wide;
		logic [7:0]      v;
		span = klen_shadow;
		if (span == 0)
			span = 1;
		else if (span > kxc_pkg::KEY_DEPTH)
			span = kxc_pkg::KEY_DEPTH;
		square = page_pos;
		square = square * square +
			(mode_shadow ? kxc_pkg::OFFSET_MAP : kxc_pkg::OFFSET_STATIC);
		slot   = square % span;
		v      = key_mirror[slot];
		if (mode_shadow) begin
			s    = (slot + 4) % 8;
			wide = {8'd0, v} << s;
			v    = wide[7:0] | (v >> s);
		end
		return v;
	endfunction

	// Advance the page index: 0..0x7fff over the first page, after that it
	// follows the position mod 0x7fff, i.e. 1..0x7ffe, 0, 1, ...
	function automatic void step_page();
		if (first_page) begin
			if (page_pos == kxc_pkg::PAGE_LEN) begin
				page_pos   = 1;
				first_page = 1'b0;
			end else begin
				page_pos = page_pos + 1'b1;
			end
		end else if (page_pos == kxc_pkg::PAGE_LEN - 1'b1) begin
			page_pos = '0;
		end else begin
			page_pos = page_pos + 1'b1;
		end
	endfunction

	// ------------------------------------------------------------------------
	// Request side
	// ------------------------------------------------------------------------

	// Offer one request and hold it until accepted, then fold it into the
	// model. Afterwards idle for a random number of cycles as the phase asks;
	// with no idle drawn, valid stays high for the next request.
	task automatic send_request(input logic op, input logic [7:0] addr,
			input logic [7:0] kb, input logic [7:0] db);
		in_valid    <= 1'b1;
		operation   <= op;
		key_address <= addr;
		key_byte    <= kb;
		data_byte   <= db;
		do @(posedge clk); while (!in_ready);
		if (op == kxc_pkg::OP_DATA) begin
			pending_plain.push_back(db ^ selected_key());
			step_page();
		end else begin
			key_mirror[addr] = kb;
		end
		while ($urandom_range(99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
	endtask

	task automatic send_random_request();
		logic op;
		op = ($urandom_range(99) < 25) ? kxc_pkg::OP_LOAD : kxc_pkg::OP_DATA;
		send_request(op, 8'($urandom_range(255)), 8'($urandom_range(255)),
			8'($urandom_range(255)));
	endtask

	// Drop valid, wait for every predicted byte, then wait out SETTLE_CYCLES
	// before anything touches the registers.
	task automatic drain_results();
		in_valid <= 1'b0;
		while (pending_plain.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [8:0] value);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		if (idx == kxc_pkg::REG_CIPHER_MODE)
			mode_shadow = value[0];
		else
			klen_shadow = value;
	endtask

	// Mode is passed as a whole register word so the upper bits get exercised.
	task automatic set_cipher(input logic [8:0] mode_word, input logic [8:0] length_word);
		drain_results();
		write_reg(kxc_pkg::REG_CIPHER_MODE, mode_word);
		write_reg(kxc_pkg::REG_KEY_LENGTH, length_word);
	endtask

	// ------------------------------------------------------------------------
	// Result side
	// ------------------------------------------------------------------------

	// Receiver: a requested hold-off wins, otherwise stall at the phase rate.
	always @(posedge clk) begin
		if (rx_hold_left > 0) begin
			out_ready <= 1'b0;
			rx_hold_left--;
		end else begin
			out_ready <= ($urandom_range(99) >= rx_stall_pct);
		end
	end

	// Compare every accepted result with the oldest prediction.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (pending_plain.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("plain byte %02h arrived with no request pending", plain_byte);
			end else begin
				plain_want = pending_plain.pop_front();
				if (plain_byte !== plain_want) begin
					mismatches++;
					if (mismatches <= 10)
						$display("plain byte: expected %02h, got %02h", plain_want, plain_byte);
				end
			end
		end
	end

	// Watchdog: end the run if neither channel moves for too long.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("keyed_square_index_xor_cipher: mismatch");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------------

	// Fill every key slot so no key length can reach an unwritten entry; put
	// the byte extremes at the first and last slot.
	task automatic test_key_preload();
		logic [7:0] kb;
		for (int a = 0; a < kxc_pkg::KEY_DEPTH; a++) begin
			kb = 8'($urandom_range(255));
			if (a == 0)
				kb = 8'hff;
			else if (a == kxc_pkg::KEY_DEPTH - 1)
				kb = 8'h00;
			send_request(kxc_pkg::OP_LOAD, 8'(a), kb, 8'($urandom_range(255)));
		end
	endtask

	// Reset leaves the static cipher with key length 1: always slot 0.
	task automatic test_reset_defaults();
		send_request(kxc_pkg::OP_DATA, 8'h00, 8'h00, 8'h00);
		send_request(kxc_pkg::OP_DATA, 8'hff, 8'hff, 8'hff);
	endtask

	// Field extremes, ignored fields carrying junk, and the map reshaping.
	task automatic test_field_extremes();
		set_cipher(9'h000, 9'd256);
		send_request(kxc_pkg::OP_DATA, 8'h00, 8'h00, 8'h00);
		send_request(kxc_pkg::OP_DATA, 8'hff, 8'hff, 8'hff);
		send_request(kxc_pkg::OP_DATA, 8'hff, 8'hff, 8'h00);
		send_request(kxc_pkg::OP_DATA, 8'h00, 8'h00, 8'hff);
		send_request(kxc_pkg::OP_LOAD, 8'h00, 8'h00, 8'hff);
		send_request(kxc_pkg::OP_LOAD, 8'hff, 8'hff, 8'h00);
		send_request(kxc_pkg::OP_DATA, 8'h5a, 8'ha5, 8'h5a);
		set_cipher(9'h1ff, 9'd256);
		send_request(kxc_pkg::OP_DATA, 8'h00, 8'h00, 8'h00);
		send_request(kxc_pkg::OP_DATA, 8'hff, 8'hff, 8'hff);
		send_request(kxc_pkg::OP_DATA, 8'h3c, 8'hc3, 8'ha5);
	endtask

	// Key length zero reads as one, lengths past the memory saturate.
	task automatic test_key_lengths();
		logic [8:0] lengths [7];
		lengths = '{9'd0, 9'd1, 9'd2, 9'd255, 9'd256, 9'd257, 9'd511};
		for (int i = 0; i < 7; i++) begin
			set_cipher(i[0] ? 9'h1ff : 9'h1fe, lengths[i]);
			send_request(kxc_pkg::OP_DATA, 8'h00, 8'h00, 8'($urandom_range(255)));
			send_request(kxc_pkg::OP_DATA, 8'hff, 8'hff, 8'($urandom_range(255)));
		end
	endtask

	// Mixed loads and data in blocks, with a fresh random setting per block.
	task automatic test_random_traffic(input int unsigned tx_pct, input int unsigned rx_pct,
			input int unsigned count);
		logic [8:0] len;
		tx_idle_pct  = tx_pct;
		rx_stall_pct = rx_pct;
		for (int unsigned n = 0; n < count; n++) begin
			if (n % RANDOM_BLOCK == 0) begin
				case ($urandom_range(5))
					0: len = 9'd0;
					1: len = 9'd1;
					2: len = 9'd256;
					3: len = 9'd511;
					default: len = 9'($urandom_range(511));
				endcase
				set_cipher(9'($urandom_range(511)), len);
			end
			send_random_request();
		end
	endtask

	// Hold the result side off while requests keep coming so the block fills
	// and stalls its input; then pause the sender until everything is back and send more.
	task automatic test_flow_pressure();
		tx_idle_pct  = 0;
		rx_stall_pct = 0;
		set_cipher(9'h001, 9'd256);
		rx_hold_left = HOLD_CYCLES;
		repeat (16) send_request(kxc_pkg::OP_DATA, 8'h00, 8'h00, 8'($urandom_range(255)));
		repeat (30) send_random_request();
		drain_results();
		repeat (30) send_random_request();
	endtask

	initial begin
		arst_n      <= 1'b0;
		cfg_we      <= 1'b0;
		cfg_index   <= kxc_pkg::REG_CIPHER_MODE;
		cfg_wdata   <= '0;
		in_valid    <= 1'b0;
		operation   <= kxc_pkg::OP_LOAD;
		key_address <= '0;
		key_byte    <= '0;
		data_byte   <= '0;
		out_ready   <= 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_key_preload();
		test_reset_defaults();
		test_field_extremes();
		test_key_lengths();
		test_random_traffic(0, 0, 250);
		test_random_traffic(68, 0, 250);
		test_random_traffic(0, 68, 250);
		test_random_traffic(11, 11, 250);
		test_flow_pressure();

		// wait for the tail, with the watchdog as the limit
		drain_results();
		if (mismatches == 0 && pending_plain.size() == 0)
			$display("keyed_square_index_xor_cipher: match");
		else
			$display("keyed_square_index_xor_cipher: mismatch");
		$finish;
	end

endmodule
